// ===== rtl/lpe_pkg.sv =====
// Shared widths, constants, control struct and helper functions for the
// Legendre polynomial evaluator. No dependencies.
package lpe_pkg;

    localparam int DEG_W   = 4;
    localparam int X_W     = 18;
    localparam int SLOPE_W = 24;
    localparam int AX_W    = 24;
    localparam int OPA_W   = 32;
    localparam int OPB_W   = 25;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 48;
    localparam int QUO_W   = PROD_W - 24;
    localparam int RECIP_W = 24;

    localparam int DEF_MAX_DEGREE = 15;
    localparam logic [DEG_W-1:0] DEGREE_RESET = 4'd5;

    localparam int ONE_Q16     = 65536;
    localparam int VAL_LIMIT   = 65536;
    localparam int SLOPE_LIMIT = 7864320;

    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ADD16 = 2'd2;
    localparam logic [1:0] ACC_SUB16 = 2'd3;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] acc_op;
        logic       n16_en;
    } lpe_ctrl_t;

    // round(2^24 / k) for k >= 2
    function automatic logic [RECIP_W-1:0] recip(input logic [DEG_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd2:    r = 24'd8388608;
            4'd3:    r = 24'd5592405;
            4'd4:    r = 24'd4194304;
            4'd5:    r = 24'd3355443;
            4'd6:    r = 24'd2796203;
            4'd7:    r = 24'd2396745;
            4'd8:    r = 24'd2097152;
            4'd9:    r = 24'd1864135;
            4'd10:   r = 24'd1677722;
            4'd11:   r = 24'd1525201;
            4'd12:   r = 24'd1398101;
            4'd13:   r = 24'd1290555;
            4'd14:   r = 24'd1198373;
            4'd15:   r = 24'd1118481;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [X_W-1:0] clamp_val(input logic signed [QUO_W-1:0] q);
        logic signed [X_W-1:0] r;
        if (q > QUO_W'(VAL_LIMIT)) begin
            r = X_W'(VAL_LIMIT);
        end else if (q < -QUO_W'(VAL_LIMIT)) begin
            r = -X_W'(VAL_LIMIT);
        end else begin
            r = X_W'(q);
        end
        return r;
    endfunction

    function automatic logic signed [SLOPE_W-1:0] clamp_slope(
        input logic signed [QUO_W-1:0] q);
        logic signed [SLOPE_W-1:0] r;
        if (q > QUO_W'(SLOPE_LIMIT)) begin
            r = SLOPE_W'(SLOPE_LIMIT);
        end else if (q < -QUO_W'(SLOPE_LIMIT)) begin
            r = -SLOPE_W'(SLOPE_LIMIT);
        end else begin
            r = SLOPE_W'(q);
        end
        return r;
    endfunction

endpackage

// ===== rtl/lpe_mac.sv =====
// Shared multiply-accumulate unit: registered product, accumulator and
// rounding to Q.16 / by 2^24. Depends on lpe_pkg.
module lpe_mac (
    input  logic                                 aclk,
    input  lpe_pkg::lpe_ctrl_t                   ctrl,
    input  logic signed [lpe_pkg::OPA_W-1:0]     op_a,
    input  logic signed [lpe_pkg::OPB_W-1:0]     op_b,
    output logic signed [lpe_pkg::PROD_W-1:0]    prod,
    output logic signed [lpe_pkg::OPA_W-1:0]     n16,
    output logic signed [lpe_pkg::QUO_W-1:0]     quo
);
    import lpe_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [OPA_W-1:0]  n16_reg, n16_next;
    logic [ACC_W-1:0]         acc_rnd;
    logic [PROD_W-1:0]        prod_rnd;

    // round half away from zero: add half, less one when negative, then shift
    assign acc_rnd  = acc_reg + ACC_W'(2 ** 15) - ACC_W'(acc_reg[ACC_W-1]);
    assign prod_rnd = prod_reg + PROD_W'(2 ** 23) - PROD_W'(prod_reg[PROD_W-1]);

    always_comb begin
        prod_next = ctrl.mul_en ? op_a * op_b : prod_reg;
        n16_next  = ctrl.n16_en ? acc_rnd[ACC_W-1:16] : n16_reg;
        case (ctrl.acc_op)
            ACC_LOAD:  acc_next = prod_reg[ACC_W-1:0];
            ACC_ADD16: acc_next = acc_reg + {prod_reg[ACC_W-17:0], 16'b0};
            ACC_SUB16: acc_next = acc_reg - {prod_reg[ACC_W-17:0], 16'b0};
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        n16_reg  <= n16_next;
    end

    assign prod = prod_reg;
    assign n16  = n16_reg;
    assign quo  = prod_rnd[PROD_W-1:24];

endmodule

// ===== rtl/legendre_polynomial_evaluator.sv =====
// Top level: sequencer, recurrence history and output register around lpe_mac.
// Depends on lpe_pkg and lpe_mac.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+----
//  input   | s_valid s_ready s_x_value                          | in
//  result  | m_valid m_ready m_order m_poly_value m_poly_slope m_last | out
//  config  | cfg_valid cfg_ready cfg_degree                     | in
//
// One item yields n+1 results (n = degree, capped at MAX_DEGREE). After the
// accept cycle it passes S_EMIT0 and, for n > 0, S_EMIT1; each further
// degree step runs S_C0 to S_C9, eight of them multiplies on the single
// shared multiplier/accumulator.
// A result waiting on m_ready stalls the sequencer at its emit state.
// Synchronous active-low reset; degree resets to 5.
module legendre_polynomial_evaluator #(
    parameter int MAX_DEGREE = lpe_pkg::DEF_MAX_DEGREE
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lpe_pkg::X_W-1:0]        s_x_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lpe_pkg::DEG_W-1:0]             m_order,
    output logic signed [lpe_pkg::X_W-1:0]        m_poly_value,
    output logic signed [lpe_pkg::SLOPE_W-1:0]    m_poly_slope,
    output logic                                  m_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lpe_pkg::DEG_W-1:0]             cfg_degree
);
    import lpe_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMIT0 = 4'd1;
    localparam logic [3:0] S_EMIT1 = 4'd2;
    localparam logic [3:0] S_C0    = 4'd3;
    localparam logic [3:0] S_C1    = 4'd4;
    localparam logic [3:0] S_C2    = 4'd5;
    localparam logic [3:0] S_C3    = 4'd6;
    localparam logic [3:0] S_C4    = 4'd7;
    localparam logic [3:0] S_C5    = 4'd8;
    localparam logic [3:0] S_C6    = 4'd9;
    localparam logic [3:0] S_C7    = 4'd10;
    localparam logic [3:0] S_C8    = 4'd11;
    localparam logic [3:0] S_C9    = 4'd12;

    logic [3:0]                state_reg, state_next;
    logic [DEG_W-1:0]          degree_reg, degree_next;
    logic [DEG_W-1:0]          n_reg, n_next;
    logic [DEG_W-1:0]          k_reg, k_next;
    logic signed [X_W-1:0]     x_reg, x_next;
    logic signed [AX_W-1:0]    ax_reg, ax_next;
    logic signed [X_W-1:0]     p1_reg, p1_next, p2_reg, p2_next;
    logic signed [SLOPE_W-1:0] d1_reg, d1_next, d2_reg, d2_next;
    logic signed [X_W-1:0]     pnew_reg, pnew_next;
    logic                      m_valid_reg, m_valid_next;
    logic [DEG_W-1:0]          m_order_reg, m_order_next;
    logic signed [X_W-1:0]     m_value_reg, m_value_next;
    logic signed [SLOPE_W-1:0] m_slope_reg, m_slope_next;
    logic                      m_last_reg, m_last_next;

    lpe_ctrl_t                 ctrl;
    logic signed [OPA_W-1:0]   op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [OPA_W-1:0]   n16;
    logic signed [QUO_W-1:0]   quo;

    logic                      out_free;
    logic                      accept;
    logic signed [X_W-1:0]     x_sat;
    logic [DEG_W-1:0]          n_sel;
    logic [DEG_W:0]            a_val;
    logic [DEG_W-1:0]          b_val;
    logic signed [SLOPE_W-1:0] dnew;

    lpe_mac u_mac (
        .aclk (aclk),
        .ctrl (ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod),
        .n16  (n16),
        .quo  (quo)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign x_sat = (s_x_value > X_W'(VAL_LIMIT))  ? X_W'(VAL_LIMIT) :
                   (s_x_value < -X_W'(VAL_LIMIT)) ? -X_W'(VAL_LIMIT) : s_x_value;
    assign n_sel = (int'(degree_reg) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : degree_reg;
    assign a_val = {k_reg, 1'b0} - (DEG_W + 1)'(1);
    assign b_val = k_reg - DEG_W'(1);
    assign dnew  = clamp_slope(quo);

    // operand selection and unit control per sequencer step
    always_comb begin
        ctrl = '{mul_en: 1'b0, acc_op: ACC_HOLD, n16_en: 1'b0};
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_C0: begin
                ctrl.mul_en = 1'b1;
                op_a = OPA_W'(x_reg);
                op_b = OPB_W'(a_val);
            end
            S_C1: begin
                ctrl.mul_en = 1'b1;
                op_a = OPA_W'($signed(prod[AX_W-1:0]));
                op_b = OPB_W'(p1_reg);
            end
            S_C2: begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_op = ACC_LOAD;
                op_a = OPA_W'(p2_reg);
                op_b = OPB_W'(b_val);
            end
            S_C3: begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_op = ACC_SUB16;
                op_a = OPA_W'(ax_reg);
                op_b = OPB_W'(d1_reg);
            end
            S_C4: begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_op = ACC_LOAD;
                ctrl.n16_en = 1'b1;
                op_a = OPA_W'(p1_reg);
                op_b = OPB_W'(a_val);
            end
            S_C5: begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_op = ACC_ADD16;
                op_a = OPA_W'(d2_reg);
                op_b = OPB_W'(b_val);
            end
            S_C6: begin
                ctrl.mul_en = 1'b1;
                ctrl.acc_op = ACC_SUB16;
                op_a = n16;
                op_b = OPB_W'(recip(k_reg));
            end
            S_C7: begin
                ctrl.n16_en = 1'b1;
            end
            S_C8: begin
                ctrl.mul_en = 1'b1;
                op_a = n16;
                op_b = OPB_W'(recip(k_reg));
            end
            default: begin
                ctrl = '{mul_en: 1'b0, acc_op: ACC_HOLD, n16_en: 1'b0};
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        degree_next  = (cfg_valid && cfg_ready) ? cfg_degree : degree_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        x_next       = x_reg;
        ax_next      = ax_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        pnew_next    = pnew_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        m_order_next = m_order_reg;
        m_value_next = m_value_reg;
        m_slope_next = m_slope_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    x_next     = x_sat;
                    n_next     = n_sel;
                    p2_next    = X_W'(ONE_Q16);
                    d2_next    = '0;
                    p1_next    = x_sat;
                    d1_next    = SLOPE_W'(ONE_Q16);
                    state_next = S_EMIT0;
                end
            end
            S_EMIT0: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_order_next = '0;
                    m_value_next = X_W'(ONE_Q16);
                    m_slope_next = '0;
                    m_last_next  = (n_reg == '0);
                    state_next   = (n_reg == '0) ? S_IDLE : S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_order_next = DEG_W'(1);
                    m_value_next = p1_reg;
                    m_slope_next = d1_reg;
                    m_last_next  = (n_reg == DEG_W'(1));
                    k_next       = DEG_W'(2);
                    state_next   = (n_reg == DEG_W'(1)) ? S_IDLE : S_C0;
                end
            end
            S_C1: begin
                ax_next    = prod[AX_W-1:0];
                state_next = S_C2;
            end
            S_C7: begin
                pnew_next  = clamp_val(quo);
                state_next = S_C8;
            end
            S_C9: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_order_next = k_reg;
                    m_value_next = pnew_reg;
                    m_slope_next = dnew;
                    m_last_next  = (k_reg == n_reg);
                    p2_next      = p1_reg;
                    d2_next      = d1_reg;
                    p1_next      = pnew_reg;
                    d1_next      = dnew;
                    k_next       = k_reg + DEG_W'(1);
                    state_next   = (k_reg == n_reg) ? S_IDLE : S_C0;
                end
            end
            S_C0, S_C2, S_C3, S_C4, S_C5, S_C6, S_C8: begin
                state_next = state_reg + 4'd1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            degree_reg  <= DEGREE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            degree_reg  <= degree_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        k_reg       <= k_next;
        x_reg       <= x_next;
        ax_reg      <= ax_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        d1_reg      <= d1_next;
        d2_reg      <= d2_next;
        pnew_reg    <= pnew_next;
        m_order_reg <= m_order_next;
        m_value_reg <= m_value_next;
        m_slope_reg <= m_slope_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_order      = m_order_reg;
    assign m_poly_value = m_value_reg;
    assign m_poly_slope = m_slope_reg;
    assign m_last       = m_last_reg;

endmodule
